// ----- hdl/skf_pkg.sv -----
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types and constants for the scalar kalman filter
// ----------------------------------------------------------------------------
package skf_pkg;

    localparam int MEAS_W   = 16;
    localparam int DATA_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int GAIN_W   = 16;
    localparam int INN_W    = DATA_W + 2;
    localparam int PROD_W   = INN_W + GAIN_W;
    localparam int STEP_W   = $clog2(GAIN_W);
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_COVARIANCE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_ESTIMATE   = 8'd3;

    localparam logic [DATA_W-1:0] RST_PROCESS_NOISE      = 32'd197;
    localparam logic [DATA_W-1:0] RST_MEASUREMENT_NOISE  = 32'd13107;
    localparam logic [DATA_W-1:0] RST_INITIAL_COVARIANCE = 32'd65536;
    localparam logic [DATA_W-1:0] RST_INITIAL_ESTIMATE   = 32'd196608;

    localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

// ----- hdl/skf_div.sv -----
// ----------------------------------------------------------------------------
// skf_div
// Restoring divider, one quotient bit per cycle, for the fractional gain
// ----------------------------------------------------------------------------
module skf_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [skf_pkg::DATA_W-1:0]      i_num,
    input  logic [skf_pkg::DATA_W:0]        i_den,
    output skf_pkg::t_unit_stat             o_stat,
    output logic [skf_pkg::GAIN_W-1:0]      o_quot
);

    logic                           r_busy;
    logic                           r_done;
    logic [skf_pkg::STEP_W-1:0]     r_cnt;
    logic [skf_pkg::DATA_W:0]       r_rem;
    logic [skf_pkg::DATA_W:0]       r_den;
    logic [skf_pkg::GAIN_W-1:0]     r_quot;

    logic [skf_pkg::DATA_W+1:0]     shifted;
    logic [skf_pkg::DATA_W+1:0]     den_ext;
    logic [skf_pkg::DATA_W+1:0]     diff;
    logic                           fits;

    // remainder stays below the divisor, so only the low bits survive
    assign shifted = {r_rem, 1'b0};
    assign den_ext = {1'b0, r_den};
    assign fits    = (shifted >= den_ext);
    assign diff    = shifted - den_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == skf_pkg::STEP_W'(skf_pkg::GAIN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, i_num};
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? diff[skf_pkg::DATA_W:0] : shifted[skf_pkg::DATA_W:0];
            r_quot <= {r_quot[skf_pkg::GAIN_W-2:0], fits};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule

// ----- hdl/skf_mul.sv -----
// ----------------------------------------------------------------------------
// skf_mul
// Shift-add multiplier, signed multiplicand by the unsigned gain, one gain
// bit per cycle with the low product bits shifting out serially
// ----------------------------------------------------------------------------
module skf_mul (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [skf_pkg::INN_W-1:0]    i_mcand,
    input  logic [skf_pkg::GAIN_W-1:0]          i_mplier,
    output skf_pkg::t_unit_stat                 o_stat,
    output logic signed [skf_pkg::PROD_W-1:0]   o_prod
);

    logic                               r_busy;
    logic                               r_done;
    logic [skf_pkg::STEP_W-1:0]         r_cnt;
    logic signed [skf_pkg::INN_W-1:0]   r_mcand;
    logic signed [skf_pkg::INN_W:0]     r_hi;
    logic [skf_pkg::GAIN_W-1:0]         r_lo;

    logic signed [skf_pkg::INN_W:0]     addend;
    logic signed [skf_pkg::INN_W:0]     sum;
    logic [skf_pkg::PROD_W:0]           full;

    assign addend = r_lo[0] ? {r_mcand[skf_pkg::INN_W-1], r_mcand} : '0;
    assign sum    = r_hi + addend;
    assign full   = {r_hi, r_lo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == skf_pkg::STEP_W'(skf_pkg::GAIN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= i_mcand;
            r_hi    <= '0;
            r_lo    <= i_mplier;
        end else if (r_busy) begin
            r_hi <= {sum[skf_pkg::INN_W], sum[skf_pkg::INN_W:1]};
            r_lo <= {sum[0], r_lo[skf_pkg::GAIN_W-1:1]};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_prod      = $signed(full[skf_pkg::PROD_W-1:0]);

endmodule

// ----- hdl/scalar_kalman_filter.sv -----
// ----------------------------------------------------------------------------
// scalar_kalman_filter
// One-dimensional kalman filter over signed 16-bit sensor samples.
//
// Each accepted item runs one filter step and yields one item with the new
// Q16.16 estimate and covariance. The prep state forms the predicted
// covariance and innovation. The bit-serial gain divider then works out the
// 16 quotient bits and hands off. The two bit-serial multipliers then run side
// by side: a load, 16 product bits and a hand-off. A last state rounds and
// saturates into the output register, once that register is free. With zero
// measurement noise the divider is skipped. The input is ready again in the
// cycle after the result is registered. The gain divider and the multipliers
// each retire one bit per cycle while busy. A new item is taken once the
// previous one reaches the output register, even while that result still
// waits to be taken. Estimate and covariance load from the initial registers
// on the first item after reset.
// ----------------------------------------------------------------------------
module scalar_kalman_filter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [skf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [skf_pkg::DATA_W-1:0]          i_cfg_data,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [15:0]                         s_axis_tdata,   // measurement
    // output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [63:0]                         m_axis_tdata    // estimate_out, covariance_out
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PREP   = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_MSTART = 3'd3;
    localparam logic [2:0] ST_MUL    = 3'd4;
    localparam logic [2:0] ST_FIN    = 3'd5;

    localparam int DW = skf_pkg::DATA_W;
    localparam int IW = skf_pkg::INN_W;
    localparam int PW = skf_pkg::PROD_W;
    localparam int FW = skf_pkg::FRAC_W;

    logic [2:0]                 r_state;
    logic [2:0]                 n_state;
    logic                       r_primed;
    logic                       r_out_valid;

    logic [DW-1:0]              r_q;
    logic [DW-1:0]              r_r;
    logic [DW-1:0]              r_p0;
    logic [DW-1:0]              r_x0;

    logic [skf_pkg::MEAS_W-1:0] r_meas;
    logic [DW-1:0]              r_est;
    logic [DW-1:0]              r_cov;
    logic [DW-1:0]              r_p1;
    logic signed [IW-1:0]       r_inn;
    logic [skf_pkg::GAIN_W-1:0] r_gain;
    logic [DW-1:0]              r_out_est;
    logic [DW-1:0]              r_out_cov;

    logic                       accept;
    logic                       out_free;
    logic [DW:0]                p_sum;
    logic [DW-1:0]              p1;
    logic [DW:0]                den;
    logic signed [IW-1:0]       inn;
    logic                       div_start;
    logic                       mul_start;
    skf_pkg::t_unit_stat        div_stat;
    skf_pkg::t_unit_stat        mx_stat;
    skf_pkg::t_unit_stat        mp_stat;
    logic [skf_pkg::GAIN_W-1:0] div_quot;
    logic signed [PW-1:0]       prod_x;
    logic signed [PW-1:0]       prod_p;
    logic signed [PW-1:0]       round_x;
    logic signed [IW:0]         nx;
    logic [DW-1:0]              est_next;
    logic [FW+DW:0]             ceil_p;
    logic [DW-1:0]              cov_next;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign out_free      = !r_out_valid || m_axis_tready;

    // predicted covariance, saturated, and innovation
    assign p_sum = {1'b0, r_cov} + {1'b0, r_q};
    assign p1    = p_sum[DW] ? {DW{1'b1}} : p_sum[DW-1:0];
    assign den   = {1'b0, p1} + {1'b0, r_r};
    assign inn   = $signed({{(IW-skf_pkg::MEAS_W-FW){r_meas[skf_pkg::MEAS_W-1]}},
                            r_meas, {FW{1'b0}}})
                 - $signed({{(IW-DW){r_est[DW-1]}}, r_est});

    assign div_start = (r_state == ST_PREP) && (r_r != '0);
    assign mul_start = (r_state == ST_MSTART);

    // estimate update, rounded half up then saturated
    assign round_x = prod_x + $signed(PW'(1 << (FW - 1)));
    assign nx      = $signed({{(IW+1-DW){r_est[DW-1]}}, r_est})
                   + $signed({round_x[PW-1], round_x[PW-1:FW]});

    always_comb begin
        if (!nx[IW] && (nx[IW-1:DW-1] != '0)) begin
            est_next = {1'b0, {(DW-1){1'b1}}};
        end else if (nx[IW] && (nx[IW-1:DW-1] != '1)) begin
            est_next = {1'b1, {(DW-1){1'b0}}};
        end else begin
            est_next = nx[DW-1:0];
        end
    end

    // covariance times one minus gain, floored, as p1 minus ceil(p1 * gain)
    assign ceil_p   = {1'b0, prod_p[FW+DW-1:0]} + (FW+DW+1)'((1 << FW) - 1);
    assign cov_next = r_p1 - ceil_p[FW+DW-1:FW];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_state = (r_r == '0) ? ST_MSTART : ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    n_state = ST_MSTART;
                end
            end
            ST_MSTART: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                if (mx_stat.done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_primed    <= 1'b0;
            r_out_valid <= 1'b0;
            r_q         <= skf_pkg::RST_PROCESS_NOISE;
            r_r         <= skf_pkg::RST_MEASUREMENT_NOISE;
            r_p0        <= skf_pkg::RST_INITIAL_COVARIANCE;
            r_x0        <= skf_pkg::RST_INITIAL_ESTIMATE;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_primed <= 1'b1;
            end
            if ((r_state == ST_FIN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    skf_pkg::REG_PROCESS_NOISE:      r_q  <= i_cfg_data;
                    skf_pkg::REG_MEASUREMENT_NOISE:  r_r  <= i_cfg_data;
                    skf_pkg::REG_INITIAL_COVARIANCE: r_p0 <= i_cfg_data;
                    skf_pkg::REG_INITIAL_ESTIMATE:   r_x0 <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_meas <= s_axis_tdata;
            if (!r_primed) begin
                r_est <= r_x0;
                r_cov <= r_p0;
            end
        end
        if (r_state == ST_PREP) begin
            r_p1  <= p1;
            r_inn <= inn;
            // no measurement noise: gain would reach one, so it is capped
            if (r_r == '0) begin
                r_gain <= (p1 == '0) ? '0 : skf_pkg::GAIN_MAX;
            end
        end
        if ((r_state == ST_DIV) && div_stat.done) begin
            r_gain <= div_quot;
        end
        if ((r_state == ST_FIN) && out_free) begin
            r_est     <= est_next;
            r_cov     <= cov_next;
            r_out_est <= est_next;
            r_out_cov <= cov_next;
        end
    end

    skf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (p1),
        .i_den   (den),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    skf_mul u_mul_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_mcand  (r_inn),
        .i_mplier (r_gain),
        .o_stat   (mx_stat),
        .o_prod   (prod_x)
    );

    skf_mul u_mul_p (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_mcand  ($signed({{(IW-DW){1'b0}}, r_p1})),
        .i_mplier (r_gain),
        .o_stat   (mp_stat),
        .o_prod   (prod_p)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_cov, r_out_est};

    a_accept_primes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_primed && (r_state == ST_PREP)))
        else $error("accepted item did not prime the filter");

    a_div_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (div_stat.busy || div_stat.done))
        else $error("waiting on an idle divider");

    a_mul_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mx_stat.done == mp_stat.done) && (mx_stat.busy == mp_stat.busy))
        else $error("multipliers out of step");

    a_cov_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |-> (cov_next <= r_p1))
        else $error("updated covariance above predicted covariance");

endmodule
